// File: hdl/dtk_pkg.sv
// Shared types and constants for the dual top-k candidate selector.
// No dependencies; every other file in hdl/ but dtk_checker refers to it by scoped names.
package dtk_pkg;

    localparam int LIMIT_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int PT_W      = 24;
    localparam int SC_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // request opcodes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [PT_W-1:0]        bottom;
        logic [PT_W-1:0]        middle;
        logic [PT_W-1:0]        top;
        logic signed [SC_W-1:0] score;
        logic signed [SC_W-1:0] origin_z;
    } cand_t;

    // control from the chain to each of its cells
    typedef struct packed {
        logic load;   // write the new candidate into the sorted row
        logic grow;   // row gains an entry (else the tail is replaced)
        logic pop;    // shift the row toward the head by one
    } chain_ctl_t;

    // status from a chain to the top level
    typedef struct packed {
        logic accepted;  // a push offered now would be stored
        logic inserted;  // ... and it takes a fresh slot
        logic empty;
        logic single;
    } chain_stat_t;

endpackage

// File: hdl/dtk_in_if.sv
// Request channel of the candidate selector: valid/ready plus one request.
// Depends on dtk_pkg for field widths.
interface dtk_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [dtk_pkg::PT_W-1:0]        bottom_point;
    logic [dtk_pkg::PT_W-1:0]        middle_point;
    logic [dtk_pkg::PT_W-1:0]        top_point;
    logic signed [dtk_pkg::SC_W-1:0] score;
    logic signed [dtk_pkg::SC_W-1:0] origin_z;
    logic                            high_quality;

    modport source (
        output valid, op, bottom_point, middle_point, top_point, score, origin_z,
               high_quality,
        input  ready
    );
    modport sink (
        input  valid, op, bottom_point, middle_point, top_point, score, origin_z,
               high_quality,
        output ready
    );
endinterface

// File: hdl/dtk_out_if.sv
// Result channel of the candidate selector: valid/ready plus one result.
// Depends on dtk_pkg for field widths.
interface dtk_out_if;
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic                            has_candidate;
    logic [dtk_pkg::PT_W-1:0]        out_bottom;
    logic [dtk_pkg::PT_W-1:0]        out_middle;
    logic [dtk_pkg::PT_W-1:0]        out_top;
    logic signed [dtk_pkg::SC_W-1:0] out_score;
    logic signed [dtk_pkg::SC_W-1:0] out_origin_z;
    logic                            out_quality;
    logic                            last;

    modport source (
        output valid, accepted, has_candidate, out_bottom, out_middle, out_top,
               out_score, out_origin_z, out_quality, last,
        input  ready
    );
    modport sink (
        input  valid, accepted, has_candidate, out_bottom, out_middle, out_top,
               out_score, out_origin_z, out_quality, last,
        output ready
    );
endinterface

// File: hdl/dtk_cell.sv
// One cell of a sorted candidate row: holds one candidate, its slot id and
// a valid bit. Depends on dtk_pkg.
module dtk_cell #(
    parameter int SLOT_W = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dtk_pkg::chain_ctl_t    ctl,
    input  dtk_pkg::cand_t         new_cand,
    input  logic [SLOT_W-1:0]      new_slot,
    input  dtk_pkg::cand_t         prev_cand,
    input  logic [SLOT_W-1:0]      prev_slot,
    input  logic                   prev_valid,
    input  logic                   prev_ahead,
    input  dtk_pkg::cand_t         next_cand,
    input  logic [SLOT_W-1:0]      next_slot,
    input  logic                   next_valid,
    output dtk_pkg::cand_t         cand,
    output logic [SLOT_W-1:0]      slot,
    output logic                   valid,
    output logic                   ahead
);

    dtk_pkg::cand_t    data_reg, data_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              valid_reg, valid_next;

    // new candidate sorts before this cell: higher score, or equal score
    // and lower slot; an empty cell is always behind it
    always_comb
    begin
        ahead = !valid_reg
             || (new_cand.score > data_reg.score)
             || ((new_cand.score == data_reg.score) && (new_slot < slot_reg));
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        slot_next  = slot_reg;
        priority if (ctl.pop)
        begin
            valid_next = next_valid;
            data_next  = next_cand;
            slot_next  = next_slot;
        end
        else if (ctl.load)
        begin
            if (ctl.grow)
            begin
                valid_next = prev_valid;
            end
            if (prev_ahead)
            begin
                data_next = prev_cand;
                slot_next = prev_slot;
            end
            else if (ahead)
            begin
                data_next = new_cand;
                slot_next = new_slot;
            end
        end
        else
        begin
            // hold
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        slot_reg <= slot_next;
    end

    assign cand  = data_reg;
    assign slot  = slot_reg;
    assign valid = valid_reg;

endmodule

// File: hdl/dtk_chain.sv
// Sorted row of dtk_cell for one quality class, best candidate at the head.
// Decides push acceptance against the class limit. Depends on dtk_pkg, dtk_cell.
module dtk_chain #(
    parameter int CAP    = 32,
    parameter int SLOT_W = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         pop,
    input  dtk_pkg::cand_t               new_cand,
    input  logic [SLOT_W-1:0]            new_slot,
    input  logic [dtk_pkg::LIMIT_W-1:0]  limit,
    output dtk_pkg::chain_stat_t         stat,
    output dtk_pkg::cand_t               head
);

    localparam int CW = $clog2(CAP + 1);
    localparam logic [dtk_pkg::LIMIT_W-1:0] CAP_L = dtk_pkg::LIMIT_W'(CAP);

    logic [CW-1:0]   count_reg, count_next;

    dtk_pkg::cand_t    cand_w  [CAP];
    logic [SLOT_W-1:0] slot_w  [CAP];
    logic [CAP:0]      valid_ext;
    logic [CAP-1:0]    ahead_w;

    logic [dtk_pkg::LIMIT_W-1:0] eff_limit;
    logic                        has_room;
    logic signed [dtk_pkg::SC_W-1:0] tail_score;
    logic [SLOT_W-1:0]           tail_slot;
    logic                        beats_tail;
    logic                        accept;
    logic [SLOT_W-1:0]           ins_slot;
    dtk_pkg::chain_ctl_t         ctl;

    assign eff_limit = (limit > CAP_L) ? CAP_L : limit;
    assign has_room  = dtk_pkg::LIMIT_W'(count_reg) < eff_limit;

    // tail is the last valid cell: the smallest weight, highest slot on ties
    always_comb
    begin
        tail_score = '0;
        tail_slot  = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (valid_ext[i] && !valid_ext[i+1])
            begin
                tail_score = cand_w[i].score;
                tail_slot  = slot_w[i];
            end
        end
    end

    assign valid_ext[CAP] = 1'b0;
    assign beats_tail     = new_cand.score > tail_score;
    assign accept         = (eff_limit != '0) && (has_room || beats_tail);
    // a replacement reuses the evicted candidate's slot
    assign ins_slot       = has_room ? new_slot : tail_slot;

    assign ctl.load = push && accept;
    assign ctl.grow = has_room;
    assign ctl.pop  = pop;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        dtk_pkg::cand_t    prev_cand_w, next_cand_w;
        logic [SLOT_W-1:0] prev_slot_w, next_slot_w;
        logic              prev_valid_w, prev_ahead_w;

        if (i == 0)
        begin : g_first
            assign prev_cand_w  = new_cand;
            assign prev_slot_w  = ins_slot;
            assign prev_valid_w = 1'b1;
            assign prev_ahead_w = 1'b0;
        end
        else
        begin : g_mid
            assign prev_cand_w  = cand_w[i-1];
            assign prev_slot_w  = slot_w[i-1];
            assign prev_valid_w = valid_ext[i-1];
            assign prev_ahead_w = ahead_w[i-1];
        end

        if (i == CAP - 1)
        begin : g_end
            assign next_cand_w = new_cand;
            assign next_slot_w = ins_slot;
        end
        else
        begin : g_inner
            assign next_cand_w = cand_w[i+1];
            assign next_slot_w = slot_w[i+1];
        end

        dtk_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_cand   (new_cand),
            .new_slot   (ins_slot),
            .prev_cand  (prev_cand_w),
            .prev_slot  (prev_slot_w),
            .prev_valid (prev_valid_w),
            .prev_ahead (prev_ahead_w),
            .next_cand  (next_cand_w),
            .next_slot  (next_slot_w),
            .next_valid (valid_ext[i+1]),
            .cand       (cand_w[i]),
            .slot       (slot_w[i]),
            .valid      (valid_ext[i]),
            .ahead      (ahead_w[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (pop && (count_reg != '0))
        begin
            count_next = count_reg - CW'(1);
        end
        else if (ctl.load && has_room)
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            // hold
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.accepted = accept;
    assign stat.inserted = has_room;
    assign stat.empty    = (count_reg == '0);
    assign stat.single   = (count_reg == CW'(1));
    assign head          = cand_w[0];

endmodule

// File: hdl/dual_top_k_candidate_selector_core.sv
// Dual top-k candidate selector. Two sorted rows of cells, one for high and one
// for low quality triplet candidates, keep each class ordered by descending
// weight (ties by ascending slot). On a push request every cell compares the
// new weight in parallel and the row shifts to make room, or, when the class
// is at its limit, drops its tail (smallest weight) if the new weight is
// strictly greater. Pushes are taken every cycle while results are consumed;
// each push returns one result with last set and accepted telling whether the
// candidate was stored. On a drain request, one result per cycle, while results
// are consumed, is popped off the head of the high row and then the low row;
// the row shift sets this pace, and an empty store gives one bare result. The
// final result has last set, and the store is empty afterwards. Requests are
// held off while a drain is in progress. limit_high/limit_low (index 0/1)
// are capped at CLASS_CAPACITY; write them only while the block is idle.
module dual_top_k_candidate_selector_core #(
    parameter int CLASS_CAPACITY = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dtk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dtk_pkg::LIMIT_W-1:0]      cfg_data,
    dtk_in_if.sink                           cand,
    dtk_out_if.source                        result
);

    localparam int SLOT_W = $clog2(2 * CLASS_CAPACITY);
    localparam int SU_W   = $clog2(2 * CLASS_CAPACITY + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                        state_reg, state_next;
    logic [dtk_pkg::LIMIT_W-1:0] limit_high_reg, limit_low_reg;
    logic [SU_W-1:0]             slots_used_reg, slots_used_next;

    // output register
    logic                        res_valid_reg, res_valid_next;
    logic                        res_accepted_reg, res_accepted_next;
    logic                        res_has_reg, res_has_next;
    dtk_pkg::cand_t              res_cand_reg, res_cand_next;
    logic                        res_quality_reg, res_quality_next;
    logic                        res_last_reg, res_last_next;

    logic                        can_load;
    logic                        push_fire, drain_fire, drain_go;
    logic                        hi_pop, lo_pop;
    dtk_pkg::cand_t              new_cand, hi_head, lo_head;
    dtk_pkg::chain_stat_t        hi_stat, lo_stat;

    // output register is free when empty or being taken this cycle
    assign can_load   = !res_valid_reg || result.ready;
    assign cand.ready = (state_reg == ST_IDLE) && can_load;
    assign push_fire  = cand.valid && cand.ready && (cand.op == dtk_pkg::OP_PUSH);
    assign drain_fire = cand.valid && cand.ready && (cand.op == dtk_pkg::OP_DRAIN);
    assign drain_go   = (state_reg == ST_DRAIN) && can_load;

    // drain order: all high candidates, then all low candidates
    assign hi_pop = drain_go && !hi_stat.empty;
    assign lo_pop = drain_go && hi_stat.empty && !lo_stat.empty;

    assign new_cand.bottom   = cand.bottom_point;
    assign new_cand.middle   = cand.middle_point;
    assign new_cand.top      = cand.top_point;
    assign new_cand.score    = cand.score;
    assign new_cand.origin_z = cand.origin_z;

    dtk_chain #(
        .CAP    (CLASS_CAPACITY),
        .SLOT_W (SLOT_W)
    ) u_chain_high (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_fire && cand.high_quality),
        .pop      (hi_pop),
        .new_cand (new_cand),
        .new_slot (slots_used_reg[SLOT_W-1:0]),
        .limit    (limit_high_reg),
        .stat     (hi_stat),
        .head     (hi_head)
    );

    dtk_chain #(
        .CAP    (CLASS_CAPACITY),
        .SLOT_W (SLOT_W)
    ) u_chain_low (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_fire && !cand.high_quality),
        .pop      (lo_pop),
        .new_cand (new_cand),
        .new_slot (slots_used_reg[SLOT_W-1:0]),
        .limit    (limit_low_reg),
        .stat     (lo_stat),
        .head     (lo_head)
    );

    // next result and sequencing
    always_comb
    begin
        res_valid_next    = (res_valid_reg && !result.ready) || push_fire || drain_go;
        res_accepted_next = res_accepted_reg;
        res_has_next      = res_has_reg;
        res_cand_next     = res_cand_reg;
        res_quality_next  = res_quality_reg;
        res_last_next     = res_last_reg;
        state_next        = state_reg;
        slots_used_next   = slots_used_reg;

        priority if (push_fire)
        begin
            res_accepted_next = cand.high_quality ? hi_stat.accepted : lo_stat.accepted;
            res_has_next      = 1'b0;
            res_cand_next     = '0;
            res_quality_next  = 1'b0;
            res_last_next     = 1'b1;
            // fresh slot only when the class grows, a replacement reuses one
            if (cand.high_quality ? (hi_stat.accepted && hi_stat.inserted)
                                  : (lo_stat.accepted && lo_stat.inserted))
            begin
                slots_used_next = slots_used_reg + SU_W'(1);
            end
        end
        else if (drain_fire)
        begin
            state_next      = ST_DRAIN;
            slots_used_next = '0;
        end
        else if (drain_go)
        begin
            res_accepted_next = 1'b0;
            priority if (!hi_stat.empty)
            begin
                res_has_next     = 1'b1;
                res_cand_next    = hi_head;
                res_quality_next = 1'b1;
                res_last_next    = hi_stat.single && lo_stat.empty;
            end
            else if (!lo_stat.empty)
            begin
                res_has_next     = 1'b1;
                res_cand_next    = lo_head;
                res_quality_next = 1'b0;
                res_last_next    = lo_stat.single;
            end
            else
            begin
                // empty store: one bare result
                res_has_next     = 1'b0;
                res_cand_next    = '0;
                res_quality_next = 1'b0;
                res_last_next    = 1'b1;
            end
            if (res_last_next)
            begin
                state_next = ST_IDLE;
            end
        end
        else
        begin
            // nothing moves: hold
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_valid_reg  <= 1'b0;
            slots_used_reg <= '0;
            limit_high_reg <= dtk_pkg::LIMIT_RESET;
            limit_low_reg  <= dtk_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            slots_used_reg <= slots_used_next;
            if (cfg_we && (cfg_index == dtk_pkg::REG_LIMIT_HIGH))
            begin
                limit_high_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == dtk_pkg::REG_LIMIT_LOW))
            begin
                limit_low_reg <= cfg_data;
            end
        end
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        res_accepted_reg <= res_accepted_next;
        res_has_reg      <= res_has_next;
        res_cand_reg     <= res_cand_next;
        res_quality_reg  <= res_quality_next;
        res_last_reg     <= res_last_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.accepted      = res_accepted_reg;
    assign result.has_candidate = res_has_reg;
    assign result.out_bottom    = res_cand_reg.bottom;
    assign result.out_middle    = res_cand_reg.middle;
    assign result.out_top       = res_cand_reg.top;
    assign result.out_score     = res_cand_reg.score;
    assign result.out_origin_z  = res_cand_reg.origin_z;
    assign result.out_quality   = res_quality_reg;
    assign result.last          = res_last_reg;

endmodule

// File: hdl/dtk_checker.sv
// Port-level checks for the candidate selector, bound to the top level.
// Depends only on the top level's ports.
module dtk_checker (
    input logic clk,
    input logic rst_n,
    input logic cand_valid,
    input logic cand_ready,
    input logic cand_op,
    input logic res_valid,
    input logic res_ready,
    input logic res_accepted,
    input logic res_has,
    input logic res_last
);

    // a pending result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    // a request is only taken when the result register can take its result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cand_valid && cand_ready |-> !res_valid || res_ready)
        else $error("request taken while result register is blocked");

    // a push answers in the next cycle with a single, final result
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        cand_valid && cand_ready && !cand_op |=> res_valid && res_last && !res_has)
        else $error("push did not produce a single result");

    // a drained candidate never claims push acceptance
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_accepted && res_has))
        else $error("accepted set on a drained candidate");

endmodule

bind dual_top_k_candidate_selector_core dtk_checker u_dtk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cand_valid   (cand.valid),
    .cand_ready   (cand.ready),
    .cand_op      (cand.op),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_accepted (result.accepted),
    .res_has      (result.has_candidate),
    .res_last     (result.last)
);
